>>> design/lmrc_pkg.sv
// ----------------------------------------------------------------------------
// lmrc_pkg
// Types and constants shared by the lift motor ramp controller.
// ----------------------------------------------------------------------------
package lmrc_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SPEED_W-1:0] STEP_INC    = 16'd5;
  localparam logic [SPEED_W-1:0] ACCEL_RESET = 16'd26;
  localparam logic [SPEED_W-1:0] SPEED_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    MODE_STOP      = 3'd0,
    MODE_PAUSE     = 3'd1,
    MODE_RAMP_UP   = 3'd2,
    MODE_RAMP_DOWN = 3'd3,
    MODE_RUN_UP    = 3'd4,
    MODE_RUN_DOWN  = 3'd5,
    MODE_SLOW      = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_UP   = 2'd1,
    REQ_DOWN = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUN_SPEED    = 2'd0,
    REG_SLOW_SPEED   = 2'd1,
    REG_ACCEL_PERIOD = 2'd2
  } reg_idx_t;

  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  typedef struct packed {
    logic [SPEED_W-1:0] cruise_speed;
    logic [SPEED_W-1:0] slow_speed;
    logic [SPEED_W-1:0] accel_period;
  } cfg_t;

  typedef struct packed {
    logic                    tick;
    logic [1:0]              request;
    logic                    up_clear;
    logic                    down_clear;
    logic                    slow_point;
    logic signed [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic               cmd_valid;
    logic               cmd_dir;
    logic [SPEED_W-1:0] cmd_speed;
    logic [2:0]         mode;
  } out_item_t;

  typedef struct packed {
    mode_t                   mode;
    logic [1:0]              pending;
    logic [SPEED_W-1:0]      ramp_speed;
    logic [SPEED_W-1:0]      elapsed;
    logic signed [POS_W-1:0] start_pos;
  } ctrl_state_t;

endpackage

>>> design/lmrc_if.sv
// ----------------------------------------------------------------------------
// lmrc_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface lmrc_in_if;
  logic               valid;
  logic               ready;
  logic               tick;
  logic [1:0]         request;
  logic               up_clear;
  logic               down_clear;
  logic               slow_point;
  logic signed [31:0] position;

  modport source (output valid, tick, request, up_clear, down_clear, slow_point,
                  position, input ready);
  modport sink (input valid, tick, request, up_clear, down_clear, slow_point,
                position, output ready);
endinterface

interface lmrc_out_if;
  logic        valid;
  logic        ready;
  logic        cmd_valid;
  logic        cmd_dir;
  logic [15:0] cmd_speed;
  logic [2:0]  mode;

  modport source (output valid, cmd_valid, cmd_dir, cmd_speed, mode, input ready);
  modport sink (input valid, cmd_valid, cmd_dir, cmd_speed, mode, output ready);
endinterface

>>> design/lmrc_step.sv
// ----------------------------------------------------------------------------
// lmrc_step
// One sequencer evaluation: next controller state and the result beat.
// ----------------------------------------------------------------------------
module lmrc_step (
  input  lmrc_pkg::cfg_t        cfg,
  input  lmrc_pkg::ctrl_state_t st,
  input  lmrc_pkg::in_item_t    item,
  output lmrc_pkg::ctrl_state_t st_next,
  output lmrc_pkg::out_item_t   res
);
  import lmrc_pkg::*;

  logic signed [POS_W:0] travel;
  logic        [POS_W:0] travel_abs;
  logic                  over_travel;
  logic [SPEED_W-1:0]    elapsed_tk;
  logic                  step_due;
  logic [SPEED_W:0]      ramp_sum;
  logic [SPEED_W-1:0]    ramp_new;

  // exact |position - start| > start, start positive
  always_comb begin
    travel      = {item.position[POS_W-1], item.position}
                - {st.start_pos[POS_W-1], st.start_pos};
    travel_abs  = travel[POS_W] ? -travel : travel;
    over_travel = !st.start_pos[POS_W-1] && (st.start_pos != '0)
                  && (travel_abs > {1'b0, st.start_pos});
  end

  always_comb begin
    elapsed_tk = st.elapsed;
    if (item.tick && st.elapsed != SPEED_MAX) begin
      elapsed_tk = st.elapsed + 16'd1;
    end
    step_due = elapsed_tk >= cfg.accel_period;
    ramp_sum = {1'b0, st.ramp_speed} + {1'b0, STEP_INC};
    ramp_new = ramp_sum[SPEED_W] ? SPEED_MAX : ramp_sum[SPEED_W-1:0];
  end

  always_comb begin
    st_next = st;
    res     = '0;
    st_next.elapsed = elapsed_tk;
    if (item.request == REQ_UP || item.request == REQ_DOWN) begin
      st_next.pending = item.request;
    end
    case (st.mode)
      MODE_PAUSE: begin
        res.cmd_valid = 1'b1;
        st_next.mode  = MODE_STOP;
      end
      MODE_STOP: begin
        if (st_next.pending == REQ_UP) begin
          if (item.up_clear) begin
            st_next.elapsed    = '0;
            st_next.mode       = MODE_RAMP_UP;
            st_next.ramp_speed = '0;
          end
          st_next.start_pos = item.position;
          st_next.pending   = REQ_NONE;
        end else if (st_next.pending == REQ_DOWN) begin
          if (item.down_clear) begin
            st_next.elapsed    = '0;
            st_next.mode       = MODE_RAMP_DOWN;
            st_next.ramp_speed = '0;
          end
          st_next.start_pos = item.position;
          st_next.pending   = REQ_NONE;
        end
      end
      MODE_RAMP_UP, MODE_RAMP_DOWN: begin
        if (over_travel) begin
          st_next.mode = MODE_PAUSE;
        end
        if (step_due) begin
          st_next.ramp_speed = ramp_new;
          if (ramp_new >= cfg.cruise_speed) begin
            st_next.mode = (st.mode == MODE_RAMP_UP) ? MODE_RUN_UP : MODE_RUN_DOWN;
          end
          res.cmd_valid   = 1'b1;
          res.cmd_dir     = (st.mode == MODE_RAMP_UP) ? DIR_UP : DIR_DOWN;
          res.cmd_speed   = ramp_new;
          st_next.elapsed = '0;
        end
        if ((st.mode == MODE_RAMP_UP) ? !item.up_clear : !item.down_clear) begin
          res.cmd_valid = 1'b1;
          res.cmd_dir   = DIR_UP;
          res.cmd_speed = '0;
          st_next.mode  = MODE_STOP;
        end
      end
      MODE_RUN_UP: begin
        if (over_travel) begin
          st_next.mode = MODE_PAUSE;
        end
        if (!item.up_clear) begin
          res.cmd_valid = 1'b1;
          st_next.mode  = MODE_STOP;
        end
      end
      MODE_RUN_DOWN: begin
        if (over_travel) begin
          st_next.mode = MODE_PAUSE;
        end
        if (!item.down_clear) begin
          res.cmd_valid = 1'b1;
          st_next.mode  = MODE_STOP;
        end else if (!item.slow_point) begin
          st_next.mode  = MODE_SLOW;
          res.cmd_valid = 1'b1;
          res.cmd_dir   = DIR_DOWN;
          res.cmd_speed = cfg.slow_speed;
        end
      end
      MODE_SLOW: begin
        if (over_travel) begin
          st_next.mode = MODE_PAUSE;
        end
        if (!item.down_clear) begin
          res.cmd_valid = 1'b1;
          st_next.mode  = MODE_STOP;
        end
      end
      default: begin
      end
    endcase
    res.mode = st_next.mode;
  end

endmodule

>>> design/lift_motor_ramp_controller.sv
// ----------------------------------------------------------------------------
// lift_motor_ramp_controller
// Lift motor sequencer: request latch, speed ramp, limit and travel checks.
// ----------------------------------------------------------------------------
// Usage:
//   item   : input beats (tick, request, clear inputs, slow point, position).
//   result : one beat per input beat (cmd_valid, cmd_dir, cmd_speed, mode).
//   cfg_we/cfg_index/cfg_data : register writes (0 run speed, 1 slow speed,
//   2 accel period); write only while no beat is in flight.
// An input beat is held in the input register, then passes through the
// sequencer logic into the result register.
// Throughput is one beat per cycle while result does not stall; the sequencer
// state updates once per beat, so beats follow back to back.
// When result stalls, the result register holds and the input register still
// takes one more beat; item.ready drops only when both are full.
// Reset (rst, synchronous) empties both registers, stops the motor state,
// clears the latched request and loads the register defaults.
// ----------------------------------------------------------------------------
module lift_motor_ramp_controller (
  input  logic                       clk,
  input  logic                       rst,
  lmrc_in_if.sink                    item,
  lmrc_out_if.source                 result,
  input  logic                       cfg_we,
  input  logic [lmrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lmrc_pkg::CFG_W-1:0] cfg_data
);
  import lmrc_pkg::*;

  cfg_t        cfg;
  ctrl_state_t st;
  ctrl_state_t st_next;
  in_item_t    in_data;
  in_item_t    in_beat;
  logic        in_valid;
  out_item_t   res;
  out_item_t   out_data;
  logic        out_valid;
  logic        out_free;
  logic        fire;

  assign in_beat.tick       = item.tick;
  assign in_beat.request    = item.request;
  assign in_beat.up_clear   = item.up_clear;
  assign in_beat.down_clear = item.down_clear;
  assign in_beat.slow_point = item.slow_point;
  assign in_beat.position   = item.position;

  assign out_free   = !out_valid || result.ready;
  assign fire       = in_valid && out_free;
  assign item.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cruise_speed <= '0;
      cfg.slow_speed   <= '0;
      cfg.accel_period <= ACCEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RUN_SPEED:    cfg.cruise_speed <= cfg_data;
        REG_SLOW_SPEED:   cfg.slow_speed   <= cfg_data;
        REG_ACCEL_PERIOD: cfg.accel_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_valid <= 1'b1;
    end else if (out_free) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_data <= in_beat;
    end
  end

  lmrc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_data),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode       <= MODE_STOP;
      st.pending    <= REQ_NONE;
      st.ramp_speed <= '0;
      st.elapsed    <= '0;
      st.start_pos  <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

  assign result.valid     = out_valid;
  assign result.cmd_valid = out_data.cmd_valid;
  assign result.cmd_dir   = out_data.cmd_dir;
  assign result.cmd_speed = out_data.cmd_speed;
  assign result.mode      = out_data.mode;

endmodule

>>> bench/lift_motor_ramp_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lift_motor_ramp_controller_test
// Self-checking bench for the lift motor sequencer. A directed run walks
// through every mode, both refused starts, the travel pause and the position
// extremes. Random trips follow: request, ramp, run, slow-down, clear drop,
// mixed with noise beats. These run under several register settings and
// several idle and stall patterns. Each result beat is compared with a
// cycle-free model of the sequencer.
// ----------------------------------------------------------------------------
module lift_motor_ramp_controller_test;
  import lmrc_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int LONG_HOLD   = 120;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 40;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  lmrc_in_if  in_ch ();
  lmrc_out_if out_ch ();

  lift_motor_ramp_controller dut (
    .clk(clk),
    .rst(rst),
    .item(in_ch),
    .result(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // sequencer model state and register copy
  mode_t              sq_mode;
  logic [1:0]         sq_pending;
  logic [SPEED_W-1:0] sq_ramp;
  logic [SPEED_W-1:0] sq_elapsed;
  logic signed [31:0] sq_start;
  logic [SPEED_W-1:0] cruise_cfg;
  logic [SPEED_W-1:0] slow_speed_cfg;
  logic [SPEED_W-1:0] accel_cfg;

  in_item_t  beat_queue[$];
  out_item_t expected_cmds[$];

  int  beats_pushed;
  int  beats_in;
  int  results_seen;
  int  cmds_checked;
  int  errors;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  sender_hold;
  int  hold_gen;
  int  hold_seen;
  int  hold_left;
  bit  in_taken;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit travel_exceeded(input logic signed [31:0] pos);
    longint span;
    span = longint'(pos) - longint'(sq_start);
    if (span < 0) span = -span;
    return (sq_start > 0) && (span > longint'(sq_start));
  endfunction

  function automatic void ramp_step(input logic dir, input mode_t run_mode,
                                    inout out_item_t r);
    logic [SPEED_W:0] bumped;
    if (sq_elapsed >= accel_cfg) begin
      bumped = {1'b0, sq_ramp} + {1'b0, STEP_INC};
      sq_ramp = bumped[SPEED_W] ? SPEED_MAX : bumped[SPEED_W-1:0];
      if (sq_ramp >= cruise_cfg) sq_mode = run_mode;
      r.cmd_valid = 1'b1;
      r.cmd_dir   = dir;
      r.cmd_speed = sq_ramp;
      sq_elapsed  = '0;
    end
  endfunction

  function automatic void stop_cmd(inout out_item_t r);
    r.cmd_valid = 1'b1;
    r.cmd_dir   = DIR_UP;
    r.cmd_speed = '0;
    sq_mode     = MODE_STOP;
  endfunction

  // one sequencer evaluation; later assignments win, as in the block
  function automatic out_item_t next_command(input in_item_t b);
    out_item_t r;
    r = '0;
    if (b.request == REQ_UP || b.request == REQ_DOWN) sq_pending = b.request;
    if (b.tick && sq_elapsed != SPEED_MAX) sq_elapsed = sq_elapsed + 16'd1;
    case (sq_mode)
      MODE_PAUSE: stop_cmd(r);
      MODE_STOP: begin
        if (sq_pending == REQ_UP) begin
          if (b.up_clear) begin
            sq_elapsed = '0;
            sq_mode    = MODE_RAMP_UP;
            sq_ramp    = '0;
          end
          sq_start   = $signed(b.position);
          sq_pending = REQ_NONE;
        end else if (sq_pending == REQ_DOWN) begin
          sq_start = $signed(b.position);
          if (b.down_clear) begin
            sq_elapsed = '0;
            sq_mode    = MODE_RAMP_DOWN;
            sq_ramp    = '0;
          end
          sq_pending = REQ_NONE;
        end
      end
      MODE_RAMP_UP: begin
        if (travel_exceeded(b.position)) sq_mode = MODE_PAUSE;
        ramp_step(DIR_UP, MODE_RUN_UP, r);
        if (!b.up_clear) stop_cmd(r);
      end
      MODE_RAMP_DOWN: begin
        if (travel_exceeded(b.position)) sq_mode = MODE_PAUSE;
        ramp_step(DIR_DOWN, MODE_RUN_DOWN, r);
        if (!b.down_clear) stop_cmd(r);
      end
      MODE_RUN_UP: begin
        if (travel_exceeded(b.position)) sq_mode = MODE_PAUSE;
        if (!b.up_clear) stop_cmd(r);
      end
      MODE_RUN_DOWN: begin
        if (travel_exceeded(b.position)) sq_mode = MODE_PAUSE;
        if (!b.down_clear) begin
          stop_cmd(r);
        end else if (!b.slow_point) begin
          sq_mode     = MODE_SLOW;
          r.cmd_valid = 1'b1;
          r.cmd_dir   = DIR_DOWN;
          r.cmd_speed = slow_speed_cfg;
        end
      end
      MODE_SLOW: begin
        if (travel_exceeded(b.position)) sq_mode = MODE_PAUSE;
        if (!b.down_clear) stop_cmd(r);
      end
      default: ;
    endcase
    r.mode = sq_mode;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (errors < MAX_REPORTS)
      $display("mismatch at result %0d: %s expected %0d got %0d",
               results_seen, what, want, got);
    errors++;
  endtask

  // input driver: payload changes on the falling edge
  always @(negedge clk) begin : drive_beats
    in_item_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // beat still on offer
    end else if (beat_queue.size() > 0 && !sender_hold &&
                 $urandom_range(99) >= send_idle_pct) begin
      nxt = beat_queue.pop_front();
      in_ch.tick       <= nxt.tick;
      in_ch.request    <= nxt.request;
      in_ch.up_clear   <= nxt.up_clear;
      in_ch.down_clear <= nxt.down_clear;
      in_ch.slow_point <= nxt.slow_point;
      in_ch.position   <= nxt.position;
      in_ch.valid      <= 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result receiver, with its own long hold-off counter
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : take_beats
    in_item_t b;
    in_taken = !rst && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      b.tick       = in_ch.tick;
      b.request    = in_ch.request;
      b.up_clear   = in_ch.up_clear;
      b.down_clear = in_ch.down_clear;
      b.slow_point = in_ch.slow_point;
      b.position   = in_ch.position;
      expected_cmds.push_back(next_command(b));
      beats_in++;
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("result beat with nothing pending", 0, 1);
      end else begin
        want = expected_cmds.pop_front();
        if (out_ch.cmd_valid !== want.cmd_valid)
          report_mismatch("cmd_valid", 32'(want.cmd_valid), 32'(out_ch.cmd_valid));
        if (out_ch.cmd_dir !== want.cmd_dir)
          report_mismatch("cmd_dir", 32'(want.cmd_dir), 32'(out_ch.cmd_dir));
        if (out_ch.cmd_speed !== want.cmd_speed)
          report_mismatch("cmd_speed", 32'(want.cmd_speed), 32'(out_ch.cmd_speed));
        if (out_ch.mode !== want.mode)
          report_mismatch("mode", 32'(want.mode), 32'(out_ch.mode));
        if (want.cmd_valid) cmds_checked++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles, %0d results pending",
                 quiet_cycles, expected_cmds.size());
        $display("FAIL lift_motor_ramp_controller");
        $finish;
      end
    end
  end

  task automatic push_beat(input logic tick, input logic [1:0] req, input logic up,
                           input logic dn, input logic slow,
                           input logic signed [31:0] pos);
    in_item_t b;
    b.tick       = tick;
    b.request    = req;
    b.up_clear   = up;
    b.down_clear = dn;
    b.slow_point = slow;
    b.position   = pos;
    beat_queue.push_back(b);
    beats_pushed++;
  endtask

  task automatic set_regs(input logic [15:0] run, input logic [15:0] slow,
                          input logic [15:0] accel);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RUN_SPEED;
    cfg_data  <= run;
    @(negedge clk);
    cfg_index <= REG_SLOW_SPEED;
    cfg_data  <= slow;
    @(negedge clk);
    cfg_index <= REG_ACCEL_PERIOD;
    cfg_data  <= accel;
    @(negedge clk);
    cfg_we <= 1'b0;
    cruise_cfg     = run;
    slow_speed_cfg = slow;
    accel_cfg      = accel;
  endtask

  task automatic drain();
    while (beats_in != beats_pushed || expected_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // request, ramp and run with positions around the start, then a clear drop
  task automatic random_trip();
    logic go_up;
    logic open;
    int   start;
    int   pos;
    int   len;
    go_up = 1'($urandom_range(1));
    open  = ($urandom_range(7) != 0);
    case ($urandom_range(3))
      0:       start = $urandom_range(1, 30);
      1:       start = $urandom_range(31, 5000);
      2:       start = -int'($urandom_range(0, 5000));
      default: start = $urandom();
    endcase
    push_beat(1'($urandom_range(1)), go_up ? REQ_UP : REQ_DOWN,
              go_up ? open : 1'($urandom_range(1)),
              go_up ? 1'($urandom_range(1)) : open, 1'($urandom_range(1)), start);
    len = $urandom_range(2, 14);
    repeat (len) begin
      case ($urandom_range(9))
        0:       pos = $urandom();
        1:       pos = 2 * start + 1 + int'($urandom_range(0, 3));
        default: pos = start + int'($urandom_range(0, 40)) - 20;
      endcase
      push_beat($urandom_range(3) != 0,
                ($urandom_range(11) == 0) ? 2'($urandom_range(3)) : REQ_NONE,
                go_up ? ($urandom_range(24) != 0) : 1'($urandom_range(1)),
                go_up ? 1'($urandom_range(1)) : ($urandom_range(24) != 0),
                $urandom_range(5) != 0, pos);
    end
    push_beat(1'($urandom_range(1)), REQ_NONE,
              go_up ? 1'b0 : 1'($urandom_range(1)),
              go_up ? 1'($urandom_range(1)) : 1'b0, 1'($urandom_range(1)), start);
  endtask

  task automatic random_run(input int n);
    int goal;
    goal = beats_pushed + n;
    while (beats_pushed < goal) begin
      if ($urandom_range(4) == 0)
        push_beat(1'($urandom_range(1)), 2'($urandom_range(3)),
                  1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom());
      else
        random_trip();
    end
  endtask

  initial begin : main
    int mark;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = REG_RUN_SPEED;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.tick       = 1'b0;
    in_ch.request    = REQ_NONE;
    in_ch.up_clear   = 1'b0;
    in_ch.down_clear = 1'b0;
    in_ch.slow_point = 1'b1;
    in_ch.position   = '0;
    out_ch.ready     = 1'b0;
    sq_mode          = MODE_STOP;
    sq_pending       = REQ_NONE;
    sq_ramp          = '0;
    sq_elapsed       = '0;
    sq_start         = '0;
    cruise_cfg       = '0;
    slow_speed_cfg   = '0;
    accel_cfg        = ACCEL_RESET;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    sender_hold      = 1'b0;
    hold_gen         = 0;
    hold_seen        = 0;
    hold_left        = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed walk through the modes
    set_regs(16'd15, 16'd7, 16'd0);
    push_beat(1'b0, REQ_UNUSED, 1'b1, 1'b1, 1'b1, 0);
    push_beat(1'b1, REQ_UP, 1'b0, 1'b1, 1'b1, 100);
    push_beat(1'b1, REQ_DOWN, 1'b1, 1'b0, 1'b1, -100);
    push_beat(1'b1, REQ_UP, 1'b1, 1'b1, 1'b1, 100);
    push_beat(1'b1, REQ_NONE, 1'b1, 1'b1, 1'b1, 120);
    push_beat(1'b0, REQ_DOWN, 1'b1, 1'b1, 1'b1, 150);
    push_beat(1'b0, REQ_UNUSED, 1'b1, 1'b1, 1'b1, 160);
    push_beat(1'b0, REQ_NONE, 1'b1, 1'b1, 1'b1, 201);
    push_beat(1'b0, REQ_NONE, 1'b1, 1'b1, 1'b1, 0);
    push_beat(1'b1, REQ_NONE, 1'b0, 1'b1, 1'b1, 32'sh8000_0000);
    push_beat(1'b1, REQ_NONE, 1'b1, 1'b1, 1'b1, 32'sh7fff_ffff);
    push_beat(1'b1, REQ_NONE, 1'b1, 1'b1, 1'b0, 32'sh7fff_ffff);
    push_beat(1'b1, REQ_NONE, 1'b1, 1'b1, 1'b1, 0);
    push_beat(1'b0, REQ_NONE, 1'b1, 1'b1, 1'b0, 0);
    push_beat(1'b0, REQ_NONE, 1'b1, 1'b0, 1'b1, 0);
    push_beat(1'b1, REQ_UP, 1'b1, 1'b0, 1'b1, 32'sh7fff_ffff);
    push_beat(1'b1, REQ_NONE, 1'b1, 1'b0, 1'b1, 32'sh8000_0000);
    push_beat(1'b1, REQ_NONE, 1'b1, 1'b1, 1'b1, 0);
    push_beat(1'b1, REQ_UP, 1'b1, 1'b1, 1'b1, 10);
    push_beat(1'b1, REQ_NONE, 1'b0, 1'b1, 1'b1, 10);
    push_beat(1'b1, REQ_DOWN, 1'b1, 1'b1, 1'b1, 50);
    push_beat(1'b1, REQ_NONE, 1'b1, 1'b1, 1'b1, 50);
    push_beat(1'b1, REQ_NONE, 1'b1, 1'b1, 1'b1, 50);
    push_beat(1'b1, REQ_NONE, 1'b1, 1'b1, 1'b1, 50);
    push_beat(1'b1, REQ_NONE, 1'b1, 1'b0, 1'b1, 50);
    drain();

    // no idling; receiver holds off long at the start so the input backs up
    set_regs(16'($urandom_range(0, 60)), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 3)));
    random_run(150);
    hold_gen++;
    drain();

    send_idle_pct = 82;
    set_regs(16'd0, 16'hFFFF, 16'hFFFF);
    random_run(100);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 82;
    set_regs(16'hFFFF, 16'd0, 16'd1);
    random_run(150);
    drain();

    // both sides idle; sender stops midway until every result is back
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    set_regs(16'($urandom_range(0, 60)), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 3)));
    mark = beats_in;
    random_run(200);
    while (beats_in < mark + 100) @(negedge clk);
    sender_hold = 1'b1;
    @(negedge clk);
    while (expected_cmds.size() != 0 || in_ch.valid) @(negedge clk);
    sender_hold = 1'b0;
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_regs(16'($urandom_range(0, 40)), 16'($urandom_range(0, 65535)), 16'd0);
    random_run(150);
    drain();
    repeat (10) @(negedge clk);

    if (expected_cmds.size() != 0)
      report_mismatch("results still pending at end", 0, expected_cmds.size());
    $display("Covered %0d beats over six register settings and four idle patterns;",
             beats_in);
    $display("%0d results compared, %0d of them speed commands, %0d mismatches.",
             results_seen, cmds_checked, errors);
    if (errors == 0) begin
      $display("PASS lift_motor_ramp_controller");
    end else begin
      $display("FAIL lift_motor_ramp_controller");
    end
    $finish;
  end

endmodule

>>> lift_motor_ramp_controller.f
design/lmrc_pkg.sv
design/lmrc_if.sv
design/lmrc_step.sv
design/lift_motor_ramp_controller.sv
bench/lift_motor_ramp_controller_test.sv
